/* rtl/qte_pkg.sv */
// ----------------------------------------------------------------------------
// qte_pkg
// Word types, fixed-point constants and tables shared by the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    typedef struct packed {
        logic [31:0]        timestamp;
        logic               first_sample;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_in_word;

    typedef struct packed {
        logic [31:0]        out_time;
        logic signed [31:0] roll_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] yaw_angle;
        logic               turn_saturated;
    } t_out_word;

    localparam int MW     = 32;   // multiplier operand width
    localparam int DW     = 4;    // multiplier digit width
    localparam int CW     = 40;   // CORDIC datapath width
    localparam int ZW     = 24;   // CORDIC angle accumulator width
    localparam int AW     = 18;   // angle width, units of 2^-14 rad
    localparam int PROD_N = 10;   // quaternion products per sample
    localparam int CFG_IW = 8;    // configuration index width

    localparam logic [CFG_IW-1:0] CFG_WRAP  = 8'd0;
    localparam logic [CFG_IW-1:0] CFG_SCALE = 8'd1;

    localparam logic signed [ZW-1:0] PI16      = 24'sd205887;
    localparam logic signed [ZW-1:0] PI14_Z    = 24'sd51472;
    localparam logic signed [AW-1:0] HALF_PI14 = 18'sd25736;
    localparam logic [MW-1:0]        TWO_PI14  = 32'd102944;
    localparam logic signed [19:0]   WRAP_TH14 = 20'sd100370;
    localparam logic signed [7:0]    TURN_MAX  = 8'sd127;

    // quaternion component codes
    localparam logic [1:0] QX = 2'd0;
    localparam logic [1:0] QY = 2'd1;
    localparam logic [1:0] QZ = 2'd2;
    localparam logic [1:0] QW = 2'd3;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = 24'sd51472;
            5'd1:    v = 24'sd30386;
            5'd2:    v = 24'sd16055;
            5'd3:    v = 24'sd8150;
            5'd4:    v = 24'sd4091;
            5'd5:    v = 24'sd2047;
            5'd6:    v = 24'sd1024;
            5'd7:    v = 24'sd512;
            5'd8:    v = 24'sd256;
            5'd9:    v = 24'sd128;
            5'd10:   v = 24'sd64;
            5'd11:   v = 24'sd32;
            5'd12:   v = 24'sd16;
            5'd13:   v = 24'sd8;
            5'd14:   v = 24'sd4;
            5'd15:   v = 24'sd2;
            5'd16:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    // operand pair of each product: wx yz wz xy wy zx ww xx yy zz
    function automatic logic [3:0] prod_sel(input logic [3:0] k);
        logic [3:0] v;
        unique case (k)
            4'd0:    v = {QW, QX};
            4'd1:    v = {QY, QZ};
            4'd2:    v = {QW, QZ};
            4'd3:    v = {QX, QY};
            4'd4:    v = {QW, QY};
            4'd5:    v = {QZ, QX};
            4'd6:    v = {QW, QW};
            4'd7:    v = {QX, QX};
            4'd8:    v = {QY, QY};
            default: v = {QZ, QZ};
        endcase
        return v;
    endfunction

endpackage

/* rtl/qte_mul.sv */
// ----------------------------------------------------------------------------
// qte_mul
// Unsigned digit-serial multiplier, one 4-bit digit of the multiplier a cycle.
// ----------------------------------------------------------------------------
module qte_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [qte_pkg::MW-1:0]      i_a,
    input  logic [qte_pkg::MW-1:0]      i_b,
    output logic                        o_done,
    output logic [2*qte_pkg::MW-1:0]    o_prod
);
    import qte_pkg::*;

    localparam int NS   = MW / DW;
    localparam int CNTW = $clog2(NS + 1);

    logic            r_busy, r_done;
    logic [CNTW-1:0] r_cnt;
    logic [MW-1:0]   r_a, r_hi, r_lo;
    logic [MW+DW-1:0] n_sum;

    assign n_sum = (MW+DW)'(r_hi) + (MW+DW)'(r_a) * (MW+DW)'(r_lo[DW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_lo   <= i_b;
                r_hi   <= '0;
            end else if (r_busy) begin
                r_hi  <= n_sum[MW+DW-1:DW];
                r_lo  <= {n_sum[DW-1:0], r_lo[MW-1:DW]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(NS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

/* rtl/qte_sqrt.sv */
// ----------------------------------------------------------------------------
// qte_sqrt
// Floor square root, one radix-4 digit of the radicand a cycle.
// ----------------------------------------------------------------------------
module qte_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2*qte_pkg::MW-1:0] i_d,
    output logic                     o_done,
    output logic [qte_pkg::MW-1:0]   o_root
);
    import qte_pkg::*;

    localparam int CNTW = $clog2(MW + 1);

    logic              r_busy, r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [2*MW-1:0]   r_rad;
    logic [MW+3:0]     r_rem;
    logic [MW-1:0]     r_root;
    logic [MW+3:0]     n_rem_s, n_trial;
    logic              n_ge;

    assign n_rem_s = {r_rem[MW+1:0], r_rad[2*MW-1:2*MW-2]};
    assign n_trial = {2'b00, r_root, 2'b01};
    assign n_ge    = n_rem_s >= n_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rad  <= i_d;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_rem_s - n_trial : n_rem_s;
                r_root <= {r_root[MW-2:0], n_ge};
                r_rad  <= {r_rad[2*MW-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(MW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* rtl/qte_cordic.sv */
// ----------------------------------------------------------------------------
// qte_cordic
// Vectoring CORDIC for atan2, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [qte_pkg::CW-1:0]    i_y,
    input  logic signed [qte_pkg::CW-1:0]    i_x,
    output logic                             o_done,
    output logic signed [qte_pkg::AW-1:0]    o_angle
);
    import qte_pkg::*;

    localparam int IW = $clog2(ITERATIONS + 1);

    logic                 r_busy, r_done, r_zero;
    logic [IW-1:0]        r_i;
    logic signed [CW-1:0] r_x, r_y, n_xs, n_ys;
    logic signed [ZW-1:0] r_z, n_rnd, n_clamp;
    logic signed [ZW-1:0] n_atan;

    assign n_xs   = r_x >>> r_i;
    assign n_ys   = r_y >>> r_i;
    assign n_atan = atan_entry(5'(r_i));
    assign n_rnd  = (r_z + 24'sd2) >>> 2;

    always_comb begin
        priority if (n_rnd > PI14_Z) begin
            n_clamp = PI14_Z;
        end else if (n_rnd < -PI14_Z) begin
            n_clamp = -PI14_Z;
        end else begin
            n_clamp = n_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_zero <= (i_x == '0) && (i_y == '0);
                if (i_x < 0) begin
                    r_x <= -i_x;
                    r_y <= -i_y;
                    r_z <= (i_y >= 0) ? PI16 : -PI16;
                end else begin
                    r_x <= i_x;
                    r_y <= i_y;
                    r_z <= '0;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + n_ys;
                    r_y <= r_y - n_xs;
                    r_z <= r_z + n_atan;
                end else begin
                    r_x <= r_x - n_ys;
                    r_y <= r_y + n_xs;
                    r_z <= r_z - n_atan;
                end
                r_i <= r_i + 1'b1;
                if (r_i == IW'(ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? '0 : AW'(n_clamp);

endmodule

/* rtl/quaternion_to_euler_unwrap.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_unwrap
// Timestamped quaternion to scaled, unwrapped roll, pitch and yaw.
//
//   channel  direction  handshake                 word
//   in       sink       i_in_valid / o_in_ready   t_in_word
//   out      source     o_out_valid / i_out_ready t_out_word
//   cfg      sink       i_cfg_valid / o_cfg_ready index + data
//
// One sample at a time: the next is accepted only after the last one's word
// is loaded into the output register. The work runs on the shared
// 4-bit-a-cycle multiplier (18 products, 16 when pitch clamps), the radix-4
// square root and one CORDIC pass per angle; a clamped pitch skips the root
// and its own CORDIC pass.
// A stale sample is dropped in the cycle it is accepted.
// Reset is synchronous; a finished word waits in the output register and
// the next sample is taken while it waits.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unwrap #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  qte_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output qte_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qte_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [23:0]                   i_cfg_data
);
    import qte_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PROD   = 4'd1;
    localparam logic [3:0] S_COMB   = 4'd2;
    localparam logic [3:0] S_CROLL  = 4'd3;
    localparam logic [3:0] S_CYAW   = 4'd4;
    localparam logic [3:0] S_NSQ    = 4'd5;
    localparam logic [3:0] S_ASQ    = 4'd6;
    localparam logic [3:0] S_SQRT   = 4'd7;
    localparam logic [3:0] S_CPITCH = 4'd8;
    localparam logic [3:0] S_UNWRAP = 4'd9;
    localparam logic [3:0] S_TURN   = 4'd10;
    localparam logic [3:0] S_SCALE  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    localparam logic [1:0] AX_ROLL  = 2'd0;
    localparam logic [1:0] AX_PITCH = 2'd1;
    localparam logic [1:0] AX_YAW   = 2'd2;

    logic [3:0]           r_state;
    logic                 r_wait;
    logic [3:0]           r_k;
    logic [1:0]           r_ax;
    t_in_word             r_in;
    logic                 r_wrap;
    logic [23:0]          r_scale;
    logic [31:0]          r_last;
    logic                 r_have;
    logic signed [31:0]   r_prod [PROD_N];
    logic signed [35:0]   r_roll_y, r_roll_x, r_yaw_y, r_yaw_x, r_sp;
    logic [35:0]          r_n2;
    logic                 r_clamp;
    logic [2*MW-1:0]      r_nsq, r_d;
    logic signed [AW-1:0] r_ang  [3];
    logic signed [AW-1:0] r_prev [3];
    logic signed [7:0]    r_turns [3];
    logic signed [24:0]   r_sum;
    logic signed [31:0]   r_res [3];
    logic                 r_ov;
    t_out_word            r_ow;

    logic signed [15:0]   q [4];
    logic [3:0]           n_sel;
    logic [35:0]          n_spa;
    logic [MW-1:0]        n_as, n_ns;
    logic                 mul_start, mul_done, sqrt_start, sqrt_done, cor_start, cor_done;
    logic [MW-1:0]        mul_a, mul_b, sqrt_root;
    logic [2*MW-1:0]      mul_p;
    logic signed [CW-1:0] cor_y, cor_x;
    logic signed [AW-1:0] cor_ang;
    logic signed [7:0]    n_turns [3];
    logic signed [31:0]   n_pv;
    logic signed [24:0]   n_tw;
    logic signed [49:0]   n_v, n_r;
    logic signed [31:0]   n_sat;
    logic                 n_tsat;

    assign q[QX] = r_in.quat_x;
    assign q[QY] = r_in.quat_y;
    assign q[QZ] = r_in.quat_z;
    assign q[QW] = r_in.quat_w;

    function automatic logic [MW-1:0] mag16(input logic signed [15:0] v);
        logic [15:0] m;
        m = v[15] ? 16'(-v) : 16'(v);
        return MW'(m);
    endfunction

    assign n_sel = prod_sel(r_k);
    assign n_spa = r_sp[35] ? 36'(-r_sp) : 36'(r_sp);
    assign n_as  = MW'(n_spa >> 2);
    assign n_ns  = MW'(r_n2 >> 2);

    assign o_in_ready  = r_state == S_IDLE;
    assign o_cfg_ready = 1'b1;

    // shared unit operands
    always_comb begin
        unique case (r_state)
            S_PROD: begin
                mul_a = mag16(q[n_sel[3:2]]);
                mul_b = mag16(q[n_sel[1:0]]);
            end
            S_NSQ: begin
                mul_a = n_ns;
                mul_b = n_ns;
            end
            S_ASQ: begin
                mul_a = n_as;
                mul_b = n_as;
            end
            S_TURN: begin
                mul_a = MW'(r_turns[r_ax] < 0 ? -r_turns[r_ax] : r_turns[r_ax]);
                mul_b = TWO_PI14;
            end
            S_SCALE: begin
                mul_a = MW'(r_sum < 0 ? -r_sum : r_sum);
                mul_b = MW'(r_scale);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_CROLL: begin
                cor_y = CW'(r_roll_y);
                cor_x = CW'(r_roll_x);
            end
            S_CYAW: begin
                cor_y = CW'(r_yaw_y);
                cor_x = CW'(r_yaw_x);
            end
            S_CPITCH: begin
                cor_y = r_sp[35] ? -CW'($signed({1'b0, n_as})) : CW'($signed({1'b0, n_as}));
                cor_x = CW'($signed({1'b0, sqrt_root}));
            end
            default: begin
                cor_y = '0;
                cor_x = '0;
            end
        endcase
    end

    assign mul_start  = !r_wait && (r_state == S_PROD || r_state == S_NSQ ||
                        r_state == S_ASQ || r_state == S_TURN || r_state == S_SCALE);
    assign sqrt_start = !r_wait && r_state == S_SQRT;
    assign cor_start  = !r_wait && (r_state == S_CROLL || r_state == S_CYAW ||
                        r_state == S_CPITCH);

    qte_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    qte_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_d     (r_d),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    qte_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_y     (cor_y),
        .i_x     (cor_x),
        .o_done  (cor_done),
        .o_angle (cor_ang)
    );

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [19:0] d;
            d = 20'(r_ang[a]) - 20'(r_prev[a]);
            n_turns[a] = r_turns[a];
            if (r_wrap && !r_in.first_sample) begin
                priority if (d > WRAP_TH14) begin
                    if (r_turns[a] > -TURN_MAX) n_turns[a] = r_turns[a] - 8'sd1;
                end else if (-d > WRAP_TH14) begin
                    if (r_turns[a] < TURN_MAX) n_turns[a] = r_turns[a] + 8'sd1;
                end
            end
        end
    end

    assign n_pv = (q[n_sel[3:2]][15] ^ q[n_sel[1:0]][15]) ? -$signed(mul_p[31:0])
                                                          : $signed(mul_p[31:0]);
    assign n_tw = r_turns[r_ax] < 0 ? -$signed(mul_p[24:0]) : $signed(mul_p[24:0]);
    assign n_v  = r_sum < 0 ? -$signed({2'b00, mul_p[47:0]}) : $signed({2'b00, mul_p[47:0]});
    assign n_r  = (n_v + 50'sd8192) >>> 14;

    always_comb begin
        priority if (n_r > 50'sd2147483647) begin
            n_sat = 32'sh7fffffff;
        end else if (n_r < -50'sd2147483648) begin
            n_sat = 32'sh80000000;
        end else begin
            n_sat = n_r[31:0];
        end
    end

    always_comb begin
        n_tsat = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (r_turns[a] == TURN_MAX || r_turns[a] == -TURN_MAX) n_tsat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_k     <= '0;
            r_ax    <= '0;
            r_wrap  <= 1'b1;
            r_scale <= 24'd65536;
            r_last  <= '0;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_prev[a]  <= '0;
                r_turns[a] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WRAP)  r_wrap  <= i_cfg_data[0];
                if (i_cfg_index == CFG_SCALE) r_scale <= i_cfg_data;
            end
            if (r_ov && i_out_ready && r_state != S_DONE) r_ov <= 1'b0;
            if (mul_start || sqrt_start || cor_start) r_wait <= 1'b1;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !(r_have && i_in_word.timestamp < r_last)) begin
                        r_have  <= 1'b1;
                        r_last  <= i_in_word.timestamp;
                        r_in    <= i_in_word;
                        r_k     <= '0;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    if (mul_done) begin
                        r_wait     <= 1'b0;
                        r_prod[r_k] <= n_pv;
                        r_k        <= r_k + 1'b1;
                        if (r_k == 4'(PROD_N - 1)) r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    r_roll_y <= (36'(r_prod[0]) + 36'(r_prod[1])) <<< 1;
                    r_roll_x <= 36'(r_prod[6]) + 36'(r_prod[9]) - 36'(r_prod[7])
                                - 36'(r_prod[8]);
                    r_yaw_y  <= (36'(r_prod[2]) + 36'(r_prod[3])) <<< 1;
                    r_yaw_x  <= 36'(r_prod[6]) + 36'(r_prod[7]) - 36'(r_prod[8])
                                - 36'(r_prod[9]);
                    r_sp     <= (36'(r_prod[4]) - 36'(r_prod[5])) <<< 1;
                    r_n2     <= 36'(r_prod[6]) + 36'(r_prod[7]) + 36'(r_prod[8])
                                + 36'(r_prod[9]);
                    r_state  <= S_CROLL;
                end
                S_CROLL: begin
                    if (cor_done) begin
                        r_wait          <= 1'b0;
                        r_ang[AX_ROLL]  <= cor_ang;
                        r_clamp         <= n_spa >= r_n2;
                        r_state         <= S_CYAW;
                    end
                end
                S_CYAW: begin
                    if (cor_done) begin
                        r_wait        <= 1'b0;
                        r_ang[AX_YAW] <= cor_ang;
                        if (r_clamp) begin
                            r_ang[AX_PITCH] <= r_sp[35] ? -HALF_PI14 : HALF_PI14;
                            r_state         <= S_UNWRAP;
                        end else begin
                            r_state <= S_NSQ;
                        end
                    end
                end
                S_NSQ: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_nsq   <= mul_p;
                        r_state <= S_ASQ;
                    end
                end
                S_ASQ: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_d     <= r_nsq - mul_p;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_wait  <= 1'b0;
                        r_state <= S_CPITCH;
                    end
                end
                S_CPITCH: begin
                    if (cor_done) begin
                        r_wait          <= 1'b0;
                        r_ang[AX_PITCH] <= cor_ang;
                        r_state         <= S_UNWRAP;
                    end
                end
                S_UNWRAP: begin
                    for (int a = 0; a < 3; a++) begin
                        r_turns[a] <= n_turns[a];
                        r_prev[a]  <= r_ang[a];
                    end
                    r_ax    <= AX_ROLL;
                    r_state <= S_TURN;
                end
                S_TURN: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_sum   <= 25'(r_ang[r_ax]) + n_tw;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (mul_done) begin
                        r_wait      <= 1'b0;
                        r_res[r_ax] <= n_sat;
                        if (r_ax == AX_YAW) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_TURN;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov                <= 1'b1;
                        r_ow.out_time       <= r_in.timestamp;
                        r_ow.roll_angle     <= r_res[AX_ROLL];
                        r_ow.pitch_angle    <= r_res[AX_PITCH];
                        r_ow.yaw_angle      <= r_res[AX_YAW];
                        r_ow.turn_saturated <= n_tsat;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

endmodule

/* rtl/qte_chk.sv */
// ----------------------------------------------------------------------------
// qte_chk
// Port-level checks on the quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
module qte_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input qte_pkg::t_in_word   i_in_word,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input qte_pkg::t_out_word  o_out_word
);
    import qte_pkg::*;

    logic        r_seen, r_in_seen;
    logic [31:0] r_last_out, r_last_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_in_seen <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                r_seen     <= 1'b1;
                r_last_out <= o_out_word.out_time;
            end
            if (i_in_valid && o_in_ready &&
                (!r_in_seen || i_in_word.timestamp >= r_last_in)) begin
                r_in_seen <= 1'b1;
                r_last_in <= i_in_word.timestamp;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word dropped or changed while stalled");

    a_time_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen |-> o_out_word.out_time >= r_last_out)
        else $error("result timestamps out of order");

    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after a sample");

    a_seen_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_in_seen && o_out_word.out_time <= r_last_in)
        else $error("result without a matching sample");

endmodule

bind quaternion_to_euler_unwrap qte_chk u_qte_chk (.*);
